@@ sv/circular_deque_unit_macros.svh @@
// assertion macros shared by the checker
`ifndef CIRCULAR_DEQUE_UNIT_MACROS_SVH
`define CIRCULAR_DEQUE_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define CDQ_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CDQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/cdq_pkg.sv @@
package cdq_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int DATA_W = 32;

	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [1:0] {
		REQ_PUSH_REAR  = 2'd0,
		REQ_PUSH_FRONT = 2'd1,
		REQ_POP_FRONT  = 2'd2,
		REQ_POP_REAR   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// wrap-around index step
	function automatic idx_t idx_inc(input idx_t i);
		return (i == IDX_W'(DEPTH - 1)) ? '0 : idx_t'(i + 1'b1);
	endfunction

	function automatic idx_t idx_dec(input idx_t i);
		return (i == '0) ? IDX_W'(DEPTH - 1) : idx_t'(i - 1'b1);
	endfunction

endpackage

@@ sv/circular_deque_unit.sv @@
// circular_deque_unit: double-ended queue in a DEPTH-slot circular memory
// a request passes the memory read into stage 1, then the output register, before out_valid
// throughput: one request per cycle unless results stall; the single-port slot memory is touched once per request
// the output register lets a new request in while a finished result waits
// reset (arst_n low) empties the deque: both indices go to zero, valids clear
// slot memory is not cleared; a pop only ever reads a slot written by a push
module circular_deque_unit
	import cdq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	// request channel
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               req_type,
	input  logic signed [DATA_W-1:0] push_value,
	// result channel
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] pop_value,
	output logic [1:0]               status,
	output logic                     now_full,
	output logic                     now_empty
);

	// deque indices: front names the free slot before the first item,
	// rear names the slot of the last item
	idx_t front_q, rear_q;
	idx_t front_nx, rear_nx;

	// slot memory, one write or one read per request
	logic signed [DATA_W-1:0] slot_mem [DEPTH];
	logic signed [DATA_W-1:0] rd_data_s1;
	logic                     mem_we, mem_re;
	idx_t                     mem_addr;

	// request decode
	logic    is_full, is_empty;
	status_t st_nx;
	logic    pop_ok_nx;
	logic    accept;

	// stage 1: memory data arrives, flags held
	logic    valid_s1;
	logic    pop_ok_s1;
	status_t status_s1;
	logic    full_s1, empty_s1;
	logic    s1_move;

	// output register
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] pop_value_q;
	status_t                  status_q;
	logic                     full_q, empty_q;

	assign is_full  = (idx_inc(rear_q) == front_q);
	assign is_empty = (front_q == rear_q);

	// stage 1 drains into the output register when that register is free or taken
	assign s1_move  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || s1_move;
	assign accept   = in_valid && in_ready;

	// index update and memory access for one request
	always_comb begin
		front_nx  = front_q;
		rear_nx   = rear_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = '0;
		st_nx     = ST_DONE;
		pop_ok_nx = 1'b0;
		unique case (req_t'(req_type))
			REQ_PUSH_REAR: begin
				if (is_full) begin
					st_nx = ST_FULL;
				end else begin
					// advance rear, then store at the new rear
					rear_nx  = idx_inc(rear_q);
					mem_we   = 1'b1;
					mem_addr = idx_inc(rear_q);
				end
			end
			REQ_PUSH_FRONT: begin
				if (is_full) begin
					st_nx = ST_FULL;
				end else begin
					// store at the free front slot, then step front back
					front_nx = idx_dec(front_q);
					mem_we   = 1'b1;
					mem_addr = front_q;
				end
			end
			REQ_POP_FRONT: begin
				if (is_empty) begin
					st_nx = ST_EMPTY;
				end else begin
					front_nx  = idx_inc(front_q);
					mem_re    = 1'b1;
					mem_addr  = idx_inc(front_q);
					pop_ok_nx = 1'b1;
				end
			end
			REQ_POP_REAR: begin
				if (is_empty) begin
					st_nx = ST_EMPTY;
				end else begin
					rear_nx   = idx_dec(rear_q);
					mem_re    = 1'b1;
					mem_addr  = rear_q;
					pop_ok_nx = 1'b1;
				end
			end
			default: begin
				st_nx = ST_DONE;
			end
		endcase
	end

	// slot memory: write and registered read; read data holds while stage 1 stalls
	always_ff @(posedge clk) begin
		if (accept && mem_we) begin
			slot_mem[mem_addr] <= push_value;
		end
		if (accept && mem_re) begin
			rd_data_s1 <= slot_mem[mem_addr];
		end
	end

	// indices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			rear_q  <= '0;
		end else if (accept) begin
			front_q <= front_nx;
			rear_q  <= rear_nx;
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// stage 1 payload, flags taken from the indices after this request
	always_ff @(posedge clk) begin
		if (accept) begin
			pop_ok_s1 <= pop_ok_nx;
			status_s1 <= st_nx;
			full_s1   <= (idx_inc(rear_nx) == front_nx);
			empty_s1  <= (front_nx == rear_nx);
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= valid_s1;
		end
	end

	// output register payload; refused requests and pushes return zero
	always_ff @(posedge clk) begin
		if (s1_move && valid_s1) begin
			pop_value_q <= pop_ok_s1 ? rd_data_s1 : '0;
			status_q    <= status_s1;
			full_q      <= full_s1;
			empty_q     <= empty_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign pop_value = pop_value_q;
	assign status    = status_q;
	assign now_full  = full_q;
	assign now_empty = empty_q;

endmodule

@@ sv/cdq_checker.sv @@
`include "circular_deque_unit_macros.svh"

module cdq_checker
	import cdq_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic [1:0]               req_type,
	input logic signed [DATA_W-1:0] push_value,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic signed [DATA_W-1:0] pop_value,
	input logic [1:0]               status,
	input logic                     now_full,
	input logic                     now_empty
);

	// a refused push leaves the deque full and returns zero
	`CDQ_ASSERT_SAME(a_full_refusal, out_valid && (status == ST_FULL), now_full && (pop_value == '0) && !now_empty, "refused push without full deque or with data")

	// a refused pop leaves the deque empty and returns zero
	`CDQ_ASSERT_SAME(a_empty_refusal, out_valid && (status == ST_EMPTY), now_empty && (pop_value == '0) && !now_full, "refused pop without empty deque or with data")

	// full and empty never hold together
	`CDQ_ASSERT_SAME(a_flags_exclusive, out_valid, !(now_full && now_empty) && (status != 2'd3), "inconsistent status flags")

	// a stalled result stays offered
	`CDQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pop_value) && $stable(status), "stalled result dropped or changed")

endmodule

bind circular_deque_unit cdq_checker u_cdq_checker (.*);
